@@ src/ptcf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the PID turn controller.
// Used by the register file, controller, datapath and top level.
package ptcf_pkg;

    localparam int POS_W  = 24;   // tracked, target, travel, error
    localparam int SUM_W  = 40;   // integral accumulator
    localparam int PROD_W = 42;   // shared 17x25 multiplier product
    localparam int ACC_W  = 58;   // PID sum before the Q8.8 floor
    localparam int ENC_W  = 21;
    localparam int DRV_W  = 7;

    localparam logic signed [POS_W:0] TRACK_STEP = 25'sd90;

    // Register indexes (word address paddr[4:2])
    localparam logic [2:0] REG_KP    = 3'd0;
    localparam logic [2:0] REG_KI    = 3'd1;
    localparam logic [2:0] REG_KD    = 3'd2;
    localparam logic [2:0] REG_FRAC  = 3'd3;
    localparam logic [2:0] REG_STEP  = 3'd4;
    localparam logic [2:0] REG_MIN   = 3'd5;
    localparam logic [2:0] REG_MAX   = 3'd6;
    localparam logic [2:0] REG_CREEP = 3'd7;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RUN   = 2'd1,
        PH_CREEP = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TGT,     // new target and tracked position
        OP_TRV,     // travel distance, clear integral terms
        OP_ERR,     // error against the target
        OP_RHS,     // fraction * travel, error delta
        OP_INTEG,   // integral gate and update, kp * err
        OP_KP,      // latch kp term, ki * sum high part
        OP_KIH,     // add ki high term, ki * sum low part
        OP_KIL,     // add ki low term, kd * delta
        OP_KD,      // add kd term
        OP_CLAMP,   // floor and clamp the drive
        OP_CREEP    // creep test against tracked position
    } t_op;

    typedef struct packed {
        logic signed [15:0] kp;
        logic signed [15:0] ki;
        logic signed [15:0] kd;
        logic        [10:0] frac;
        logic signed [12:0] step;
        logic        [6:0]  drv_min;
        logic        [6:0]  drv_max;
        logic        [6:0]  creep;
    } t_cfg;

    typedef struct packed {
        logic load;   // capture an input beat
        logic emit;   // move the result into the output register
        t_op  op;
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   err_neg;
        logic   out_free;
    } t_sts;

    function automatic logic signed [POS_W-1:0] sat24(input logic signed [POS_W:0] x);
        logic signed [POS_W-1:0] r;
        if (x[POS_W] != x[POS_W-1])
            r = x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        else
            r = x[POS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat40(input logic signed [SUM_W:0] x);
        logic signed [SUM_W-1:0] r;
        if (x[SUM_W] != x[SUM_W-1])
            r = x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            r = x[SUM_W-1:0];
        return r;
    endfunction

endpackage

@@ src/ptcf_cfg_regs.sv @@
`timescale 1ns / 1ps
// APB-style register file for the PID turn controller gains and limits.
// Depends on ptcf_pkg.
module ptcf_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output ptcf_pkg::t_cfg o_cfg
);
    import ptcf_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp      <= 16'sd256;
            r_cfg.ki      <= 16'sd0;
            r_cfg.kd      <= 16'sd0;
            r_cfg.frac    <= 11'd512;
            r_cfg.step    <= 13'sd90;
            r_cfg.drv_min <= 7'd3;
            r_cfg.drv_max <= 7'd100;
            r_cfg.creep   <= 7'd3;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_KP:    r_cfg.kp      <= pwdata[15:0];
                REG_KI:    r_cfg.ki      <= pwdata[15:0];
                REG_KD:    r_cfg.kd      <= pwdata[15:0];
                REG_FRAC:  r_cfg.frac    <= pwdata[10:0];
                REG_STEP:  r_cfg.step    <= pwdata[12:0];
                REG_MIN:   r_cfg.drv_min <= pwdata[6:0];
                REG_MAX:   r_cfg.drv_max <= pwdata[6:0];
                REG_CREEP: r_cfg.creep   <= pwdata[6:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_KP:    prdata = {16'd0, r_cfg.kp};
            REG_KI:    prdata = {16'd0, r_cfg.ki};
            REG_KD:    prdata = {16'd0, r_cfg.kd};
            REG_FRAC:  prdata = {21'd0, r_cfg.frac};
            REG_STEP:  prdata = {19'd0, r_cfg.step};
            REG_MIN:   prdata = {25'd0, r_cfg.drv_min};
            REG_MAX:   prdata = {25'd0, r_cfg.drv_max};
            REG_CREEP: prdata = {25'd0, r_cfg.creep};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

@@ src/ptcf_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the PID turn controller: steps the datapath through one beat.
// Depends on ptcf_pkg.
module ptcf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req_type,
    input  ptcf_pkg::t_sts i_sts,
    output logic           o_in_stall,
    output ptcf_pkg::t_cmd o_cmd
);
    import ptcf_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_TGT   = 13'b0000000000010,
        S_TRV   = 13'b0000000000100,
        S_ERR   = 13'b0000000001000,
        S_RHS   = 13'b0000000010000,
        S_INTEG = 13'b0000000100000,
        S_KP    = 13'b0000001000000,
        S_KIH   = 13'b0000010000000,
        S_KIL   = 13'b0000100000000,
        S_KD    = 13'b0001000000000,
        S_CLAMP = 13'b0010000000000,
        S_CREEP = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_req_type)
                        n_state = S_TGT;
                    else if (i_sts.phase == PH_RUN)
                        n_state = S_ERR;
                    else if (i_sts.phase == PH_CREEP)
                        n_state = S_CREEP;
                    else
                        n_state = S_EMIT;
                end
            end
            S_TGT: begin
                o_cmd.op = OP_TGT;
                n_state  = S_TRV;
            end
            S_TRV: begin
                o_cmd.op = OP_TRV;
                n_state  = S_EMIT;
            end
            S_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = S_RHS;
            end
            S_RHS: begin
                o_cmd.op = OP_RHS;
                n_state  = S_INTEG;
            end
            S_INTEG: begin
                o_cmd.op = OP_INTEG;
                n_state  = i_sts.err_neg ? S_CREEP : S_KP;
            end
            S_KP: begin
                o_cmd.op = OP_KP;
                n_state  = S_KIH;
            end
            S_KIH: begin
                o_cmd.op = OP_KIH;
                n_state  = S_KIL;
            end
            S_KIL: begin
                o_cmd.op = OP_KIL;
                n_state  = S_KD;
            end
            S_KD: begin
                o_cmd.op = OP_KD;
                n_state  = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.op = OP_CLAMP;
                n_state  = S_EMIT;
            end
            S_CREEP: begin
                o_cmd.op = OP_CREEP;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/ptcf_dp.sv @@
`timescale 1ns / 1ps
// Datapath for the PID turn controller: position state, shared multiplier,
// PID accumulator and output register. Depends on ptcf_pkg.
module ptcf_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptcf_pkg::t_cmd       i_cmd,
    input  ptcf_pkg::t_cfg       i_cfg,
    input  logic                 i_req_type,
    input  logic signed [20:0]   i_encoder_position,
    input  logic                 i_out_stall,
    output ptcf_pkg::t_sts       o_sts,
    output logic                 o_out_valid,
    output logic [6:0]           o_drive,
    output logic                 o_done_res
);
    import ptcf_pkg::*;

    // architectural state
    logic signed [POS_W-1:0] r_tracked, r_target, r_travel, r_prev;
    logic signed [SUM_W-1:0] r_esum;
    t_phase                  r_phase;

    // per-beat working registers
    logic signed [ENC_W-1:0]  r_enc;
    logic signed [POS_W-1:0]  r_err;
    logic signed [POS_W:0]    r_delta;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [DRV_W-1:0]         r_res_drive;
    logic                     r_res_done;
    logic                     r_out_valid;
    logic [DRV_W-1:0]         r_out_drive;
    logic                     r_out_done;

    logic signed [16:0]       mul_a;
    logic signed [POS_W:0]    mul_b;
    logic signed [POS_W-1:0]  enc_ext;
    logic signed [POS_W-1:0]  err_now;
    logic signed [PROD_W-1:0] lhs;
    logic                     acc_en;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [49:0]       floor_d;
    logic signed [49:0]       lo_d;
    logic [DRV_W-1:0]         clamp_d;
    logic                     out_free;

    assign enc_ext  = {{(POS_W-ENC_W){r_enc[ENC_W-1]}}, r_enc};
    assign err_now  = sat24({r_target[POS_W-1], r_target} - {enc_ext[POS_W-1], enc_ext});
    assign lhs      = {{(PROD_W-ENC_W-10){r_enc[ENC_W-1]}}, r_enc, 10'd0};
    assign acc_en   = r_travel[POS_W-1] ? (lhs < r_prod) : (lhs > r_prod);
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign floor_d  = r_acc[ACC_W-1:8];
    assign out_free = !r_out_valid || !i_out_stall;

    // raise to the minimum first, then cap, so the maximum wins
    always_comb begin
        lo_d = (floor_d < $signed({43'd0, i_cfg.drv_min})) ? $signed({43'd0, i_cfg.drv_min})
                                                            : floor_d;
        clamp_d = (lo_d > $signed({43'd0, i_cfg.drv_max})) ? i_cfg.drv_max : lo_d[DRV_W-1:0];
    end

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_RHS: begin
                mul_a = {6'd0, i_cfg.frac};
                mul_b = {r_travel[POS_W-1], r_travel};
            end
            OP_INTEG: begin
                mul_a = {i_cfg.kp[15], i_cfg.kp};
                mul_b = {r_err[POS_W-1], r_err};
            end
            OP_KP: begin
                mul_a = {i_cfg.ki[15], i_cfg.ki};
                mul_b = {{9{r_esum[SUM_W-1]}}, r_esum[SUM_W-1:POS_W]};
            end
            OP_KIH: begin
                mul_a = {i_cfg.ki[15], i_cfg.ki};
                mul_b = {1'b0, r_esum[POS_W-1:0]};
            end
            OP_KIL: begin
                mul_a = {i_cfg.kd[15], i_cfg.kd};
                mul_b = r_delta;
            end
            default: begin
                mul_a = 17'sd0;
                mul_b = 25'sd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_enc       <= i_encoder_position;
            r_res_drive <= '0;
            r_res_done  <= i_req_type && (r_phase == PH_DONE);
        end
        case (i_cmd.op)
            OP_ERR:   r_err   <= err_now;
            OP_RHS:   r_delta <= {r_err[POS_W-1], r_err} - {r_prev[POS_W-1], r_prev};
            OP_KP:    r_acc   <= prod_ext;
            OP_KIH:   r_acc   <= r_acc + {r_prod[ACC_W-POS_W-1:0], {POS_W{1'b0}}};
            OP_KIL:   r_acc   <= r_acc + prod_ext;
            OP_KD:    r_acc   <= r_acc + prod_ext;
            OP_CLAMP: r_res_drive <= clamp_d;
            OP_CREEP: begin
                if (enc_ext < r_tracked) begin
                    r_res_drive <= i_cfg.creep;
                end else begin
                    r_res_drive <= '0;
                    r_res_done  <= 1'b1;
                end
            end
            default: ;
        endcase
        if (i_cmd.emit) begin
            r_out_drive <= r_res_drive;
            r_out_done  <= r_res_done;
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked   <= '0;
            r_target    <= '0;
            r_travel    <= '0;
            r_prev      <= '0;
            r_esum      <= '0;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_TGT: begin
                    r_target <= sat24({r_tracked[POS_W-1], r_tracked}
                                      + {{(POS_W-12){i_cfg.step[12]}}, i_cfg.step});
                    if (!i_cfg.step[12] && i_cfg.step != 13'sd0)
                        r_tracked <= sat24({r_tracked[POS_W-1], r_tracked} + TRACK_STEP);
                    else if (i_cfg.step[12])
                        r_tracked <= sat24({r_tracked[POS_W-1], r_tracked} - TRACK_STEP);
                end
                OP_TRV: begin
                    r_travel <= err_now;
                    r_esum   <= '0;
                    r_prev   <= '0;
                    r_phase  <= PH_RUN;
                end
                OP_INTEG: begin
                    if (acc_en)
                        r_esum <= sat40({r_esum[SUM_W-1], r_esum}
                                        + {{(SUM_W-POS_W+1){r_err[POS_W-1]}}, r_err});
                end
                OP_CLAMP: r_prev <= r_err;
                OP_CREEP: r_phase <= (enc_ext < r_tracked) ? PH_CREEP : PH_DONE;
                default: ;
            endcase
            if (i_cmd.emit)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    assign o_sts.phase    = r_phase;
    assign o_sts.err_neg  = r_err[POS_W-1];
    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_valid;
    assign o_drive        = r_out_drive;
    assign o_done_res     = r_out_done;

endmodule

@@ src/pid_turn_with_creep_finish.sv @@
`timescale 1ns / 1ps
// PID position controller for one motor with a creep finish.
// Top level: register file, sequencer and datapath. Depends on ptcf_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one beat per request:
//   i_req_type 0 starts a move from the tracked position, 1 is a control
//   tick with the current i_encoder_position. Every beat yields exactly one
//   result beat on the output channel (o_out_valid / i_out_stall) with the
//   motor drive and the done flag.
//   One beat is in flight at a time; o_in_stall is high while it is worked.
//   A start runs the target and travel steps. A run-phase tick runs the error,
//   integral, kp, ki and kd steps and the clamp, using the shared 17x25 multiplier
//   five times; if its error turns negative it leaves after the integral step for
//   the creep test. A creep tick runs the creep test alone. The next beat is taken
//   the cycle after the result is loaded.
//   The result sits in an output register; while i_out_stall is high it is
//   held and a finished next result waits in the sequencer.
//   The user writes registers over the APB port only while the block is idle; the block does not enforce it.
//   Reset (i_rst_n low, synchronous) restores register defaults, clears the
//   tracked position, target, travel and integral terms, and returns to idle.
module pid_turn_with_creep_finish (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request beats
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic signed [20:0] i_encoder_position,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [6:0]         o_drive,
    output logic               o_done_res
);
    import ptcf_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    ptcf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: one beat at a time, commands the datapath step by step
    ptcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // datapath: holds position state, runs the PID sum, drives the output beat
    ptcf_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_cfg              (cfg),
        .i_req_type         (i_req_type),
        .i_encoder_position (i_encoder_position),
        .i_out_stall        (i_out_stall),
        .o_sts              (sts),
        .o_out_valid        (o_out_valid),
        .o_drive            (o_drive),
        .o_done_res         (o_done_res)
    );

endmodule

@@ src/ptcf_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the PID turn controller, bound to the top level.
// Sees only the top-level ports.
module ptcf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [6:0]  o_drive,
    input logic        o_done_res
);

    // one beat in flight: an accepted beat closes the input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a beat is in flight");

    // a result appears only from a busy sequencer
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work");

    // a finished move always reports the motor stopped
    a_done_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (o_drive == 7'd0))
        else $error("done with nonzero drive");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_drive) && $stable(o_done_res)))
        else $error("stalled result changed");

endmodule

bind pid_turn_with_creep_finish ptcf_checker u_ptcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_drive     (o_drive),
    .o_done_res  (o_done_res)
);

@@ tb/pid_turn_with_creep_finish_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for pid_turn_with_creep_finish: checks every drive/done beat
// against a built-in copy of the controller. Depends on ptcf_pkg and the block only.
module pid_turn_with_creep_finish_tb;
    import ptcf_pkg::*;

    localparam bit     REQ_START   = 1'b0;
    localparam bit     REQ_TICK    = 1'b1;
    localparam longint ENC_MIN     = -1048576;
    localparam longint ENC_MAX     = 1048575;
    localparam longint FRAC_ONE    = 1024;      // Q0.10 unity
    localparam int     QUIET_LIMIT = 2000;      // cycles without any beat moving
    localparam int     LONG_HOLD   = 150;
    localparam int     PHASE_BEATS = 115;

    typedef struct {
        bit                 kind;
        logic signed [20:0] enc;
        bit                 drain;   // hold this beat back until all results are in
    } t_req_beat;

    typedef struct {
        logic [6:0] drive;
        bit         done;
    } t_drive_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_req_type = 1'b0;
    logic signed [20:0] i_encoder_position = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [6:0]         o_drive;
    logic               o_done_res;

    pid_turn_with_creep_finish DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_req_type         (i_req_type),
        .i_encoder_position (i_encoder_position),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_drive            (o_drive),
        .o_done_res         (o_done_res)
    );

    always #1 i_clk = ~i_clk;

    // Request beats waiting to be offered, and the drive beats still owed by the block.
    t_req_beat   req_q[$];
    t_drive_beat drive_due_q[$];

    int  mismatch_cnt = 0;
    int  beat_no      = 0;
    int  quiet_cycles = 0;
    int  queued_cnt   = 0;
    int  tx_wait      = 0;
    int  rx_wait      = 0;
    int  hold_left    = 0;
    bit  in_taken     = 1'b0;   // set at the rising edge, consumed at the falling edge
    bit  out_taken    = 1'b0;
    bit  calm         = 1'b0;   // no idling on either side
    bit  long_hold_go = 1'b0;
    longint gen_trk;            // stimulus-side guess of the tracked position

    // ------------------------------------------------------------------
    // Controller copy: settings and state at the block's own widths
    // ------------------------------------------------------------------
    t_cfg   cfg;
    longint trk_pos, tgt_pos, travel, integ, prev_err;
    t_phase ctl_phase;

    function automatic longint clip(input longint x, input int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    function automatic void clear_controller();
        cfg.kp      = 16'sd256;
        cfg.ki      = '0;
        cfg.kd      = '0;
        cfg.frac    = 11'd512;
        cfg.step    = 13'sd90;
        cfg.drv_min = 7'd3;
        cfg.drv_max = 7'd100;
        cfg.creep   = 7'd3;
        trk_pos   = 0;
        tgt_pos   = 0;
        travel    = 0;
        integ     = 0;
        prev_err  = 0;
        ctl_phase = PH_IDLE;
    endfunction

    // Work out the drive beat for one accepted request and advance the state.
    function automatic void compute_drive(input bit kind, input logic signed [20:0] pos,
                                          output logic [6:0] drive, output bit done);
        longint enc, err, lhs, rhs, delta, acc, d;
        bit     gate;
        enc   = pos;
        drive = '0;
        done  = 1'b0;
        if (kind == REQ_START) begin
            tgt_pos = clip(trk_pos + longint'(cfg.step), POS_W);
            if (cfg.step > 0)
                trk_pos = clip(trk_pos + longint'(TRACK_STEP), POS_W);
            else if (cfg.step < 0)
                trk_pos = clip(trk_pos - longint'(TRACK_STEP), POS_W);
            travel    = clip(tgt_pos - enc, POS_W);
            integ     = 0;
            prev_err  = 0;
            ctl_phase = PH_RUN;
        end else if (ctl_phase == PH_RUN) begin
            err = clip(tgt_pos - enc, POS_W);
            // encoder/travel > fraction, cross-multiplied; flip for negative travel
            lhs  = enc * FRAC_ONE;
            rhs  = longint'(cfg.frac) * travel;
            gate = (travel < 0) ? (lhs < rhs) : (lhs > rhs);
            if (gate)
                integ = clip(integ + err, SUM_W);
            delta = err - prev_err;
            if (err < 0) begin
                ctl_phase = PH_CREEP;
            end else begin
                acc = longint'(cfg.kp) * err + longint'(cfg.ki) * integ
                    + longint'(cfg.kd) * delta;
                d = acc >>> 8;   // floor of the Q8.8 sum
                // raise to the floor first, then cap: the cap wins when they cross
                if (d < longint'(cfg.drv_min)) d = longint'(cfg.drv_min);
                if (d > longint'(cfg.drv_max)) d = longint'(cfg.drv_max);
                drive    = d[6:0];
                prev_err = err;
            end
        end else if (ctl_phase == PH_DONE) begin
            done = 1'b1;
        end
        // the tick that first sees a negative error also runs the creep test
        if (kind == REQ_TICK && ctl_phase == PH_CREEP) begin
            if (enc < trk_pos) begin
                drive = cfg.creep;
            end else begin
                drive     = '0;
                done      = 1'b1;
                ctl_phase = PH_DONE;
            end
        end
    endfunction

    // Bits each register keeps; a read returns them zero-extended.
    function automatic logic [31:0] reg_mask(input logic [2:0] idx);
        case (idx)
            REG_KP, REG_KI, REG_KD:     return 32'h0000_FFFF;
            REG_FRAC:                   return 32'h0000_07FF;
            REG_STEP:                   return 32'h0000_1FFF;
            REG_MIN, REG_MAX, REG_CREEP: return 32'h0000_007F;
            default:                    return 32'h0000_0000;
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 200)
            $display("%0t: result beat %0d: %s", $time, beat_no, what);
    endtask

    // ------------------------------------------------------------------
    // Request driver: change at the falling edge, hold a beat until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        bit        holding;
        t_req_beat nxt;
        holding = i_in_valid;
        if (in_taken) begin
            in_taken = 1'b0;
            holding  = 1'b0;
            tx_wait  = calm ? 0 : $urandom_range(0, 4);
        end
        if (!holding) begin
            if (tx_wait != 0) begin
                tx_wait--;
                i_in_valid <= 1'b0;
            end else if (req_q.size() != 0
                         && !(req_q[0].drain && drive_due_q.size() != 0)) begin
                nxt = req_q.pop_front();
                i_in_valid         <= 1'b1;
                i_req_type         <= nxt.kind;
                i_encoder_position <= nxt.enc;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: stall each result at random, or hold off for a
    // long stretch on request so the block backs up into its input
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (long_hold_go) begin
            long_hold_go = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (out_taken) begin
            out_taken = 1'b0;
            rx_wait   = calm ? 0 : $urandom_range(0, 4);
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_wait != 0 && o_out_valid) begin
            rx_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every request beat, compare every result beat,
    // and watch for a stuck block
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_drive_beat due, want;
        bit          moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                compute_drive(i_req_type, i_encoder_position, due.drive, due.done);
                drive_due_q.push_back(due);
                in_taken = 1'b1;
                moved    = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                out_taken = 1'b1;
                moved     = 1'b1;
                beat_no++;
                if (drive_due_q.size() == 0) begin
                    flag_mismatch("result beat with nothing outstanding");
                end else begin
                    want = drive_due_q.pop_front();
                    if (o_drive !== want.drive)
                        flag_mismatch($sformatf("drive %0d, expected %0d",
                                                o_drive, want.drive));
                    if (o_done_res !== want.done)
                        flag_mismatch($sformatf("done %b, expected %b",
                                                o_done_res, want.done));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(input bit kind, input longint pos, input bit drain);
        t_req_beat r;
        r.kind  = kind;
        r.enc   = pos[20:0];
        r.drain = drain;
        req_q.push_back(r);
        queued_cnt++;
    endtask

    // Wait until every beat is offered, taken and answered, then let the block settle.
    task automatic settle(input int extra);
        while (req_q.size() != 0 || i_in_valid || drive_due_q.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        // the register reads back what was just written
        if (prdata !== (val & reg_mask(idx)))
            flag_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                    idx, prdata, val & reg_mask(idx)));
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(REG_KP,    32'(c.kp));
        write_reg(REG_KI,    32'(c.ki));
        write_reg(REG_KD,    32'(c.kd));
        write_reg(REG_FRAC,  32'(c.frac));
        write_reg(REG_STEP,  32'(c.step));
        write_reg(REG_MIN,   32'(c.drv_min));
        write_reg(REG_MAX,   32'(c.drv_max));
        write_reg(REG_CREEP, 32'(c.creep));
        cfg = c;
        @(posedge i_clk);
    endtask

    // One well-formed move: a start, then ticks that ramp the encoder through
    // the target and on to the tracked position, plus up to two more ticks at the last reading.
    task automatic queue_move(input bit drain);
        longint goal, home, lo, hi, ramp0, last, pos;
        int     n;
        goal = gen_trk + longint'(cfg.step);
        if (cfg.step > 0)
            home = gen_trk + longint'(TRACK_STEP);
        else if (cfg.step < 0)
            home = gen_trk - longint'(TRACK_STEP);
        else
            home = gen_trk;
        lo    = (goal < home) ? goal : home;
        hi    = (goal < home) ? home : goal;
        ramp0 = lo - longint'($urandom_range(0, 600));
        // start past the target now and then so the travel comes out negative
        if ($urandom_range(0, 5) == 0)
            pos = hi + longint'($urandom_range(1, 300));
        else
            pos = ramp0;
        push_req(REQ_START, pos, drain);
        gen_trk = home;
        n    = $urandom_range(2, 12);
        last = hi + longint'($urandom_range(0, 40));
        for (int k = 0; k <= n; k++)
            push_req(REQ_TICK, ramp0 + (last - ramp0) * k / n
                               + longint'($urandom_range(0, 6)) - 3, 1'b0);
        repeat ($urandom_range(0, 2)) push_req(REQ_TICK, last, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        t_cfg c;
        clear_controller();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // Reset settings: ticks while idle at zero and the top encoder reading, a start from the
        // most negative reading, an overshoot straight to done, ticks after done,
        // then a start with zero travel and a run down to the low clamp.
        push_req(REQ_TICK, 0, 1'b0);
        push_req(REQ_TICK, ENC_MAX, 1'b0);
        push_req(REQ_START, ENC_MIN, 1'b0);
        push_req(REQ_TICK, ENC_MIN, 1'b0);
        push_req(REQ_TICK, ENC_MAX, 1'b0);
        push_req(REQ_TICK, 0, 1'b0);
        push_req(REQ_START, 180, 1'b0);
        push_req(REQ_TICK, 1, 1'b0);
        push_req(REQ_TICK, 178, 1'b0);
        push_req(REQ_TICK, 180, 1'b0);
        push_req(REQ_TICK, 181, 1'b0);
        settle(4);

        // Crossed clamps and a target short of the tracked position, so the
        // block creeps before it finishes.
        c         = cfg;
        c.ki      = 16'sd256;
        c.kd      = -16'sd256;
        c.step    = -13'sd200;
        c.drv_min = 7'd50;
        c.drv_max = 7'd20;
        c.creep   = 7'd7;
        load_config(c);
        push_req(REQ_START, -100, 1'b0);
        push_req(REQ_TICK, -50, 1'b0);
        push_req(REQ_TICK, 0, 1'b0);
        push_req(REQ_TICK, 60, 1'b0);
        push_req(REQ_TICK, 95, 1'b0);
        push_req(REQ_TICK, 95, 1'b0);
        settle(4);

        // Zero step: target sits on the tracked position, which stays put.
        c.step = '0;
        load_config(c);
        push_req(REQ_START, 60, 1'b0);
        push_req(REQ_TICK, 80, 1'b0);
        push_req(REQ_TICK, 95, 1'b0);
        settle(4);

        // Random phases, each under its own register setting.
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin
                    c.kp      = 16'($urandom_range(64, 1024));
                    c.ki      = 16'($urandom_range(0, 64));
                    c.kd      = 16'($urandom_range(0, 512));
                    c.frac    = 11'($urandom_range(0, 1024));
                    c.step    = 13'(int'($urandom_range(0, 600)) - 300);
                    c.drv_min = 7'($urandom_range(0, 10));
                    c.drv_max = 7'($urandom_range(50, 100));
                    c.creep   = 7'($urandom_range(1, 20));
                end
                1: begin
                    c.kp      = 16'sd32767;
                    c.ki      = 16'sd32767;
                    c.kd      = 16'sd32767;
                    c.frac    = 11'd1024;
                    c.step    = 13'sd4095;
                    c.drv_min = 7'd100;
                    c.drv_max = 7'd100;
                    c.creep   = 7'd100;
                end
                2: begin
                    c.kp      = -16'sd32768;
                    c.ki      = -16'sd32768;
                    c.kd      = -16'sd32768;
                    c.frac    = '0;
                    c.step    = -13'sd4096;
                    c.drv_min = '0;
                    c.drv_max = '0;
                    c.creep   = '0;
                end
                3: begin
                    c.kp      = 16'sd256;
                    c.ki      = 16'sd16;
                    c.kd      = -16'sd128;
                    c.frac    = 11'd700;
                    c.step    = 13'sd45;
                    c.drv_min = 7'd80;
                    c.drv_max = 7'd30;
                    c.creep   = 7'd5;
                end
                default: begin
                    c.kp      = 16'($urandom);
                    c.ki      = 16'($urandom);
                    c.kd      = 16'($urandom);
                    c.frac    = 11'($urandom_range(0, 1024));
                    c.step    = 13'($urandom);
                    c.drv_min = 7'($urandom_range(0, 100));
                    c.drv_max = 7'($urandom_range(0, 100));
                    c.creep   = 7'($urandom_range(0, 100));
                end
            endcase
            load_config(c);
            gen_trk    = trk_pos;
            calm       = (p == 3);
            queued_cnt = 0;
            // open the phase with a move the sender holds until the block is drained
            queue_move(1'b1);
            while (queued_cnt < PHASE_BEATS) begin
                if ($urandom_range(0, 99) < 80) begin
                    queue_move($urandom_range(0, 4) == 0);
                end else begin
                    // noise: any request type at any encoder reading
                    repeat ($urandom_range(1, 3))
                        push_req(1'($urandom_range(0, 1)), longint'($urandom), 1'b0);
                    gen_trk = trk_pos;
                end
            end
            // back the block up: receiver holds off while requests keep coming
            if (p == 0 || p == 5)
                long_hold_go = 1'b1;
            settle(4);
        end

        settle(12);
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
